@@ rtl/motion_profile_generator_macros.svh @@
// Assertion macros shared by the motion profile generator RTL.
`ifndef MOTION_PROFILE_GENERATOR_MACROS_SVH
`define MOTION_PROFILE_GENERATOR_MACROS_SVH

// check a condition in the same cycle as its trigger
`define MPG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a condition in the cycle after its trigger
`define MPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mpg_pkg.sv @@
// Shared types, codes and helpers of the motion profile generator.
package mpg_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DT_BITS       = 16;
    localparam int REG_W         = 31;
    localparam int PADDR_W       = 5;
    localparam int ROOT_STEPS    = 32;
    localparam int DIV_NUM_W     = 49;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_TARGET = 2'd1,
        KIND_RESET  = 2'd2,
        KIND_RATE   = 2'd3
    } kind_t;

    localparam logic [1:0] MODE_OFF        = 2'd0;
    localparam logic [1:0] MODE_TRAP       = 2'd1;
    localparam logic [1:0] MODE_SCURVE     = 2'd2;
    localparam logic [1:0] MODE_SCURVE_ALT = 2'd3;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_MAX_RATE  = 3'd1;
    localparam logic [2:0] REG_MAX_ACCEL = 3'd2;
    localparam logic [2:0] REG_MAX_JERK  = 3'd3;
    localparam logic [2:0] REG_TOL       = 3'd4;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_APPLY,
        CMD_ERR,
        CMD_SQR,
        CMD_PROD,
        CMD_BRAKE,
        CMD_ROOT_GO,
        CMD_WANT,
        CMD_DIV_GO,
        CMD_ACC,
        CMD_DIFF,
        CMD_STEP,
        CMD_RSTEP,
        CMD_ASTEP,
        CMD_VMUL,
        CMD_VADD,
        CMD_PMUL,
        CMD_PADD,
        CMD_ARRIVE,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [REG_W-1:0] speed_cap;
        logic [REG_W-1:0] max_accel;
        logic [REG_W-1:0] jerk_cap;
        logic [REG_W-1:0] tol;
    } cfg_t;

    typedef struct packed {
        logic kind_tick;
        logic mode_off;
        logic scurve;
        logic dt_zero;
        logic brake;
        logic root_busy;
        logic div_busy;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/mpg_sqrt.sv @@
// Iterative floor square root, one root bit per cycle.
module mpg_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);
    import mpg_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg;
    logic [32:0] rem_reg;
    logic [31:0] root_reg;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic [34:0] sub;
    logic        ge;

    assign rem_sh = {rem_reg, x_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;
    assign sub    = rem_sh - trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(ROOT_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= ge ? sub[32:0] : rem_sh[32:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

@@ rtl/mpg_div.sv @@
// Restoring divider of the scaled rate error by the time step, one bit per cycle.
module mpg_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mpg_pkg::DIV_NUM_W-1:0]  numer,
    input  logic [mpg_pkg::DT_BITS-1:0]    denom,
    output logic                           busy,
    output logic [mpg_pkg::DIV_NUM_W-1:0]  quot
);
    import mpg_pkg::*;

    logic                 busy_reg, busy_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DT_BITS-1:0]   rem_reg;
    logic [DT_BITS-1:0]   den_reg;
    logic [DT_BITS:0]     rem_sh;
    logic [DT_BITS:0]     sub;
    logic                 ge;

    assign rem_sh = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign sub    = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'(DIV_NUM_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], ge};
            rem_reg <= ge ? sub[DT_BITS-1:0] : rem_sh[DT_BITS-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = num_reg;

endmodule

@@ rtl/mpg_dp.sv @@
// Datapath: motion state, planning arithmetic, iterative units and result register.
module mpg_dp #(
    parameter int FRAC_BITS = mpg_pkg::FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mpg_pkg::cmd_t               cmd,
    output mpg_pkg::status_t            status,
    input  mpg_pkg::cfg_t               cfg,
    input  logic [1:0]                  kind,
    input  logic signed [31:0]          operand_value,
    input  logic [mpg_pkg::DT_BITS-1:0] step_time,
    output logic signed [31:0]          planned_value,
    output logic signed [31:0]          planned_rate,
    output logic                        arrived,
    output logic                        moving
);
    import mpg_pkg::*;

    localparam logic [32:0] DEF_TOL = 33'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

    // motion state
    logic signed [31:0] tgt_reg, tgt_next;
    logic signed [31:0] pos_reg, pos_next;
    logic signed [31:0] rate_reg, rate_next;
    logic signed [31:0] accel_reg, accel_next;
    logic               busy_reg, busy_next;

    // item and working registers
    logic [1:0]         kind_reg;
    logic signed [31:0] opnd_reg;
    logic [DT_BITS-1:0] dt_reg;
    logic [32:0]        dist_reg;
    logic               dir_neg_reg;
    logic               dir_zero_reg;
    logic [31:0]        rabs_reg;
    logic [63:0]        r2_reg;
    logic [63:0]        pa_reg;
    logic [63:0]        prod_reg;
    logic               brake_reg;
    logic signed [35:0] diff_reg;
    logic [46:0]        dtmul_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] step_reg;
    logic [47:0]        mul_reg;
    logic               mneg_reg;
    logic signed [31:0] res_value_reg;
    logic signed [31:0] res_rate_reg;
    logic               res_arr_reg;
    logic               res_mov_reg;
    logic signed [31:0] out_value_reg;
    logic signed [31:0] out_rate_reg;
    logic               out_arr_reg;
    logic               out_mov_reg;

    logic signed [32:0] err33;
    logic [32:0]        dist_c;
    logic signed [32:0] opd33;
    logic [32:0]        opd_abs;
    logic signed [32:0] rate33;
    logic [32:0]        rabs33;
    logic signed [32:0] accel33;
    logic [32:0]        aabs33;
    logic [31:0]        a2;
    logic [31:0]        root;
    logic               root_busy;
    logic [32:0]        lim_c;
    logic signed [35:0] sgnlim;
    logic signed [35:0] want_c;
    logic [35:0]        dabs_c;
    logic [DIV_NUM_W-1:0] quot;
    logic               div_busy;
    logic               qbig;
    logic [30:0]        qmag;
    logic signed [31:0] acc_c;
    logic [30:0]        slim;
    logic signed [31:0] step_c;
    logic [30:0]        dtm_a;
    logic [31:0]        mul_a;
    logic signed [32:0] tdt33;
    logic [32:0]        tol_c;
    logic               at_goal;

    assign err33   = {tgt_reg[31], tgt_reg} - {pos_reg[31], pos_reg};
    assign dist_c  = err33[32] ? 33'(-err33) : 33'(err33);
    assign opd33   = {opnd_reg[31], opnd_reg} - {pos_reg[31], pos_reg};
    assign opd_abs = opd33[32] ? 33'(-opd33) : 33'(opd33);
    assign rate33  = {rate_reg[31], rate_reg};
    assign rabs33  = rate33[32] ? 33'(-rate33) : 33'(rate33);
    assign accel33 = {accel_reg[31], accel_reg};
    assign aabs33  = accel33[32] ? 33'(-accel33) : 33'(accel33);
    assign a2      = {cfg.max_accel, 1'b0};

    assign lim_c  = brake_reg ? {1'b0, root} : {2'b00, cfg.speed_cap};
    assign sgnlim = dir_zero_reg ? 36'sd0
                  : (dir_neg_reg ? -$signed({3'b000, lim_c}) : $signed({3'b000, lim_c}));
    assign want_c = sgnlim - {{4{rate_reg[31]}}, rate_reg};
    assign dabs_c = diff_reg[35] ? 36'(-diff_reg) : 36'(diff_reg);

    assign qbig  = quot > {18'd0, cfg.max_accel};
    assign qmag  = qbig ? cfg.max_accel : quot[30:0];
    assign acc_c = (dt_reg == '0) ? 32'sd0
                 : (diff_reg[35] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag}));

    assign slim   = dtmul_reg[46:16];
    assign step_c = (dabs_c > {5'd0, slim})
                  ? (diff_reg[35] ? -$signed({1'b0, slim}) : $signed({1'b0, slim}))
                  : diff_reg[31:0];

    assign dtm_a = (cmd == CMD_ACC) ? cfg.jerk_cap : cfg.max_accel;
    assign mul_a = (cmd == CMD_VMUL) ? aabs33[31:0] : rabs33[31:0];
    assign tdt33 = mneg_reg ? -$signed({1'b0, mul_reg[47:16]}) : $signed({1'b0, mul_reg[47:16]});

    assign tol_c   = (cfg.tol != '0) ? {2'b00, cfg.tol} : DEF_TOL;
    assign at_goal = (dist_reg <= tol_c) && (rabs33 <= tol_c);

    mpg_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd == CMD_ROOT_GO && brake_reg),
        .radicand (prod_reg),
        .busy     (root_busy),
        .root     (root)
    );

    mpg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd == CMD_DIV_GO && dt_reg != '0),
        .numer ({dabs_c[32:0], 16'd0}),
        .denom (dt_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    always_comb
    begin
        tgt_next   = tgt_reg;
        pos_next   = pos_reg;
        rate_next  = rate_reg;
        accel_next = accel_reg;
        busy_next  = busy_reg;
        case (cmd)
            CMD_APPLY:
            begin
                case (kind_reg)
                    KIND_TARGET:
                    begin
                        tgt_next  = opnd_reg;
                        busy_next = opd_abs > DEF_TOL;
                    end
                    KIND_RESET:
                    begin
                        tgt_next   = opnd_reg;
                        pos_next   = opnd_reg;
                        rate_next  = '0;
                        accel_next = '0;
                        busy_next  = 1'b0;
                    end
                    KIND_RATE:
                        rate_next = opnd_reg;
                    default:
                        busy_next = busy_reg;
                endcase
            end
            CMD_RSTEP:
                rate_next = sat32(rate33 + {step_reg[31], step_reg});
            CMD_ASTEP:
                accel_next = sat32(accel33 + {step_reg[31], step_reg});
            CMD_VADD:
                rate_next = sat32(rate33 + tdt33);
            CMD_PADD:
                pos_next = sat32({pos_reg[31], pos_reg} + tdt33);
            CMD_ARRIVE:
            begin
                if (at_goal)
                begin
                    pos_next   = tgt_reg;
                    rate_next  = '0;
                    accel_next = '0;
                    busy_next  = 1'b0;
                end
                else
                    busy_next = 1'b1;
            end
            default:
                busy_next = busy_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg   <= '0;
            pos_reg   <= '0;
            rate_reg  <= '0;
            accel_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            tgt_reg   <= tgt_next;
            pos_reg   <= pos_next;
            rate_reg  <= rate_next;
            accel_reg <= accel_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                kind_reg <= kind;
                opnd_reg <= operand_value;
                dt_reg   <= step_time;
            end
            CMD_APPLY:
            begin
                res_arr_reg <= 1'b0;
                res_mov_reg <= busy_next;
                case (kind_reg)
                    KIND_TARGET:
                    begin
                        res_value_reg <= pos_reg;
                        res_rate_reg  <= rate_reg;
                    end
                    KIND_RESET:
                    begin
                        res_value_reg <= opnd_reg;
                        res_rate_reg  <= '0;
                    end
                    KIND_RATE:
                    begin
                        res_value_reg <= pos_reg;
                        res_rate_reg  <= opnd_reg;
                    end
                    default:
                    begin
                        res_value_reg <= tgt_reg;
                        res_rate_reg  <= '0;
                        res_arr_reg   <= 1'b1;
                    end
                endcase
            end
            CMD_ERR:
            begin
                dist_reg     <= dist_c;
                dir_neg_reg  <= err33[32];
                dir_zero_reg <= (err33 == '0);
                rabs_reg     <= rabs33[31:0];
            end
            CMD_SQR:
            begin
                r2_reg <= rabs_reg * rabs_reg;
                pa_reg <= dist_reg[31:0] * a2;
            end
            CMD_PROD:
                prod_reg <= pa_reg + (dist_reg[32] ? {a2, 32'd0} : 64'd0);
            CMD_BRAKE:
                brake_reg <= (cfg.max_accel != '0) ? (prod_reg <= r2_reg) : (dist_reg == '0);
            CMD_WANT:
            begin
                diff_reg  <= want_c;
                dtmul_reg <= dtm_a * dt_reg;
            end
            CMD_ACC:
            begin
                acc_reg   <= acc_c;
                dtmul_reg <= dtm_a * dt_reg;
            end
            CMD_DIFF:
                diff_reg <= {{4{acc_reg[31]}}, acc_reg} - {{4{accel_reg[31]}}, accel_reg};
            CMD_STEP:
                step_reg <= step_c;
            CMD_VMUL:
            begin
                mul_reg  <= mul_a * dt_reg;
                mneg_reg <= accel_reg[31];
            end
            CMD_PMUL:
            begin
                mul_reg  <= mul_a * dt_reg;
                mneg_reg <= rate_reg[31];
            end
            CMD_ARRIVE:
            begin
                res_value_reg <= pos_reg;
                res_rate_reg  <= rate_reg;
                res_arr_reg   <= at_goal;
                res_mov_reg   <= !at_goal;
            end
            CMD_OUT:
            begin
                out_value_reg <= res_value_reg;
                out_rate_reg  <= res_rate_reg;
                out_arr_reg   <= res_arr_reg;
                out_mov_reg   <= res_mov_reg;
            end
            default:
                mneg_reg <= mneg_reg;
        endcase
    end

    assign status.kind_tick = (kind_reg == KIND_TICK);
    assign status.mode_off  = (cfg.mode == MODE_OFF);
    assign status.scurve    = (cfg.mode != MODE_OFF) && (cfg.mode != MODE_TRAP);
    assign status.dt_zero   = (dt_reg == '0);
    assign status.brake     = brake_reg;
    assign status.root_busy = root_busy;
    assign status.div_busy  = div_busy;

    assign planned_value = out_value_reg;
    assign planned_rate  = out_rate_reg;
    assign arrived       = out_arr_reg;
    assign moving        = out_mov_reg;

endmodule

@@ rtl/mpg_ctrl.sv @@
// Controller: sequences one item through the datapath and runs both handshakes.
module mpg_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mpg_pkg::status_t status,
    output mpg_pkg::cmd_t    cmd
);
    import mpg_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE      = 21'h000001,
        S_DECODE    = 21'h000002,
        S_SQR       = 21'h000004,
        S_PROD      = 21'h000008,
        S_BRAKE     = 21'h000010,
        S_ROOT_GO   = 21'h000020,
        S_ROOT_WAIT = 21'h000040,
        S_WANT      = 21'h000080,
        S_DIV_GO    = 21'h000100,
        S_DIV_WAIT  = 21'h000200,
        S_ACC       = 21'h000400,
        S_DIFF      = 21'h000800,
        S_STEP      = 21'h001000,
        S_RSTEP     = 21'h002000,
        S_ASTEP     = 21'h004000,
        S_VMUL      = 21'h008000,
        S_VADD      = 21'h010000,
        S_PMUL      = 21'h020000,
        S_PADD      = 21'h040000,
        S_ARRIVE    = 21'h080000,
        S_DONE      = 21'h100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = CMD_NONE;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!status.kind_tick || status.mode_off)
                begin
                    cmd        = CMD_APPLY;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_ERR;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                cmd        = CMD_SQR;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd        = CMD_PROD;
                state_next = S_BRAKE;
            end
            S_BRAKE:
            begin
                cmd        = CMD_BRAKE;
                state_next = S_ROOT_GO;
            end
            S_ROOT_GO:
            begin
                cmd        = CMD_ROOT_GO;
                state_next = status.brake ? S_ROOT_WAIT : S_WANT;
            end
            S_ROOT_WAIT:
            begin
                if (!status.root_busy)
                    state_next = S_WANT;
            end
            S_WANT:
            begin
                cmd        = CMD_WANT;
                state_next = status.scurve ? S_DIV_GO : S_STEP;
            end
            S_DIV_GO:
            begin
                cmd        = CMD_DIV_GO;
                state_next = status.dt_zero ? S_ACC : S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!status.div_busy)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd        = CMD_ACC;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd        = CMD_DIFF;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd        = CMD_STEP;
                state_next = status.scurve ? S_ASTEP : S_RSTEP;
            end
            S_RSTEP:
            begin
                cmd        = CMD_RSTEP;
                state_next = S_PMUL;
            end
            S_ASTEP:
            begin
                cmd        = CMD_ASTEP;
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                cmd        = CMD_VMUL;
                state_next = S_VADD;
            end
            S_VADD:
            begin
                cmd        = CMD_VADD;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                cmd        = CMD_PMUL;
                state_next = S_PADD;
            end
            S_PADD:
            begin
                cmd        = CMD_PADD;
                state_next = S_ARRIVE;
            end
            S_ARRIVE:
            begin
                cmd        = CMD_ARRIVE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/motion_profile_generator.sv @@
// Top level of the motion profile generator: register port, controller and datapath.
//
// Plans a trapezoidal or jerk-limited approach of a Q16.16 position toward its target,
// one item at a time. Set-target, reset-to-value, set-rate and disabled-mode ticks are
// applied in the decode state and then go to the done state. A trapezoid tick waits on
// the 32-step square root unit when the position lies inside the braking distance; an
// S-curve tick adds 5 extra steps, and the 49-step divider when dt is nonzero.
// The next item is taken the cycle after the result has moved into the output
// register, which holds it until the consumer takes it.
`include "motion_profile_generator_macros.svh"

module motion_profile_generator #(
    parameter int FRAC_BITS = mpg_pkg::FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpg_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic signed [31:0]           operand_value,
    input  logic [mpg_pkg::DT_BITS-1:0]  step_time,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           planned_value,
    output logic signed [31:0]           planned_rate,
    output logic                         arrived,
    output logic                         moving
);
    import mpg_pkg::*;

    localparam logic [REG_W-1:0] ONE = REG_W'(64'd1 << FRAC_BITS);

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;
    status_t    status;
    cmd_t       cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:      cfg_next.mode      = pwdata[1:0];
                REG_MAX_RATE:  cfg_next.speed_cap = pwdata[REG_W-1:0];
                REG_MAX_ACCEL: cfg_next.max_accel = pwdata[REG_W-1:0];
                REG_MAX_JERK:  cfg_next.jerk_cap  = pwdata[REG_W-1:0];
                REG_TOL:       cfg_next.tol       = pwdata[REG_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_OFF;
            cfg_reg.speed_cap <= ONE;
            cfg_reg.max_accel <= ONE;
            cfg_reg.jerk_cap  <= ONE;
            cfg_reg.tol       <= '0;
        end
        else
            cfg_reg <= cfg_next;
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE:      prdata = {30'd0, cfg_reg.mode};
            REG_MAX_RATE:  prdata = {1'b0, cfg_reg.speed_cap};
            REG_MAX_ACCEL: prdata = {1'b0, cfg_reg.max_accel};
            REG_MAX_JERK:  prdata = {1'b0, cfg_reg.jerk_cap};
            REG_TOL:       prdata = {1'b0, cfg_reg.tol};
            default:       prdata = '0;
        endcase
    end

    mpg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mpg_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg_reg),
        .kind          (kind),
        .operand_value (operand_value),
        .step_time     (step_time),
        .planned_value (planned_value),
        .planned_rate  (planned_rate),
        .arrived       (arrived),
        .moving        (moving)
    );

    `MPG_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")
    `MPG_ASSERT_NEXT(a_min_latency, in_valid && in_ready, !$rose(out_valid), "result too early")
    `MPG_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(!in_ready), "result from idle")

endmodule
